// File: hdl/bsrp_pkg.sv
// Shared types and constants for the decision-diagram set stream parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package bsrp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] FORMAT_VERSION = 16'h0001;
  localparam logic [63:0] HEADER_BYTES   = 64'd16;
  localparam logic [36:0] TERMINAL_BYTES = 37'd8;
  localparam logic [36:0] COUNT_BYTES    = 37'd4;

  typedef enum logic [1:0] {
    KIND_NODE     = 2'd0,
    KIND_TERMINAL = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_ERROR    = 2'd3
  } record_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TRUNCATED     = 3'd1,
    ERR_BAD_MAGIC     = 3'd2,
    ERR_BAD_VERSION   = 3'd3,
    ERR_EXTRA_DATA    = 3'd4,
    ERR_READ_TOO_MUCH = 3'd5
  } error_code_t;

  // Event passed from front to back; node_last and terminal expand to two results
  typedef enum logic [1:0] {
    EV_NODE      = 2'd0,
    EV_NODE_LAST = 2'd1,
    EV_TERMINAL  = 2'd2,
    EV_ERROR     = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } byte_item_t;

  typedef struct packed {
    record_kind_t       record_kind;
    logic [31:0]        node_number;
    logic [7:0]         variable_index;
    logic signed [31:0] low_reference;
    logic signed [31:0] high_reference;
    logic [31:0]        terminal_value;
    error_code_t        error_code;
    logic               last_of_run;
  } result_item_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [31:0]        node_number;
    logic [7:0]         variable_index;
    logic signed [31:0] low_reference;
    logic signed [31:0] high_reference;
    logic [31:0]        terminal_value;
    error_code_t        error_code;
    logic               len_short;   // implied bytes below declared length
    logic               len_over;    // implied bytes above declared length
  } parse_event_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } queue_status_t;

  // Magic string "IP set", one byte per position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h49;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h20;
      3'd3:    val = 8'h73;
      3'd4:    val = 8'h65;
      3'd5:    val = 8'h74;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/bsrp_front.sv
// Front end: takes one byte per cycle on accept, assembles fields and raises events.
// Depends on bsrp_pkg.
module bsrp_front
  import bsrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  byte_item_t   byte_data,
  output logic         push,
  output parse_event_t evt
);

  typedef enum logic [8:0] {
    PH_MAGIC    = 9'b000000001,
    PH_VERSION  = 9'b000000010,
    PH_LENGTH   = 9'b000000100,
    PH_COUNT    = 9'b000001000,
    PH_TERMINAL = 9'b000010000,
    PH_VAR      = 9'b000100000,
    PH_LOW      = 9'b001000000,
    PH_HIGH     = 9'b010000000,
    PH_DONE     = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  field_cnt, field_cnt_next;
  logic        magic_bad, magic_bad_next;
  logic [31:0] nodes_done, nodes_done_next;
  logic [63:0] declared_length, declared_length_next;
  logic [31:0] nodes_expected, nodes_expected_next;
  logic [31:0] shift_word, shift_word_next;
  logic [7:0]  held_variable, held_variable_next;
  logic [31:0] held_low_ref, held_low_ref_next;
  logic [36:0] implied_bytes, implied_bytes_next;
  logic        len_short, len_over;

  logic [7:0]  b;
  logic [31:0] sw;
  logic [31:0] node_num;
  logic [63:0] cap;
  logic        bad;

  assign b        = byte_data.data_byte;
  assign sw       = {shift_word[23:0], b};
  assign node_num = nodes_done + 32'd1;
  assign cap      = declared_length - HEADER_BYTES;
  assign bad      = magic_bad | (b != magic_byte(field_cnt));

  // Parse step for one accepted byte or end marker
  always_comb begin
    phase_next           = phase;
    field_cnt_next       = field_cnt;
    magic_bad_next       = magic_bad;
    nodes_done_next      = nodes_done;
    declared_length_next = declared_length;
    nodes_expected_next  = nodes_expected;
    shift_word_next      = shift_word;
    held_variable_next   = held_variable;
    held_low_ref_next    = held_low_ref;
    implied_bytes_next   = implied_bytes;
    push                 = 1'b0;
    evt                  = '0;
    evt.kind             = EV_ERROR;
    evt.error_code       = ERR_NONE;
    evt.len_short        = len_short;
    evt.len_over         = len_over;

    if (accept) begin
      if (byte_data.stream_end) begin
        // Rearm; an unfinished parse reports truncation
        if (phase != PH_DONE) begin
          push           = 1'b1;
          evt.kind       = EV_ERROR;
          evt.error_code = ERR_TRUNCATED;
        end
        phase_next      = PH_MAGIC;
        field_cnt_next  = 3'd0;
        magic_bad_next  = 1'b0;
        nodes_done_next = 32'd0;
      end else begin
        unique case (phase)
          PH_MAGIC: begin
            if (field_cnt == 3'd5) begin
              field_cnt_next = 3'd0;
              magic_bad_next = 1'b0;
              if (bad) begin
                push           = 1'b1;
                evt.error_code = ERR_BAD_MAGIC;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_VERSION;
              end
            end else begin
              field_cnt_next = field_cnt + 3'd1;
              magic_bad_next = bad;
            end
          end
          PH_VERSION: begin
            shift_word_next = sw;
            if (field_cnt == 3'd1) begin
              field_cnt_next = 3'd0;
              if (sw[15:0] != FORMAT_VERSION) begin
                push           = 1'b1;
                evt.error_code = ERR_BAD_VERSION;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_LENGTH;
              end
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          PH_LENGTH: begin
            declared_length_next = {declared_length[55:0], b};
            if (field_cnt == 3'd7) begin
              field_cnt_next = 3'd0;
              phase_next     = PH_COUNT;
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          PH_COUNT: begin
            shift_word_next = sw;
            if (field_cnt == 3'd3) begin
              field_cnt_next      = 3'd0;
              nodes_expected_next = sw;
              if (sw == 32'd0) begin
                implied_bytes_next = TERMINAL_BYTES;
                phase_next         = PH_TERMINAL;
              end else begin
                // 4 + 9 * count
                implied_bytes_next = COUNT_BYTES + {2'b00, sw, 3'b000} + {5'b00000, sw};
                phase_next         = PH_VAR;
              end
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          PH_TERMINAL: begin
            shift_word_next = sw;
            if (field_cnt == 3'd3) begin
              field_cnt_next     = 3'd0;
              push               = 1'b1;
              evt.kind           = EV_TERMINAL;
              evt.terminal_value = sw;
              phase_next         = PH_DONE;
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          PH_VAR: begin
            held_variable_next = b;
            field_cnt_next     = 3'd0;
            phase_next         = PH_LOW;
          end
          PH_LOW: begin
            shift_word_next = sw;
            if (field_cnt == 3'd3) begin
              field_cnt_next    = 3'd0;
              held_low_ref_next = sw;
              phase_next        = PH_HIGH;
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          PH_HIGH: begin
            shift_word_next = sw;
            if (field_cnt == 3'd3) begin
              field_cnt_next     = 3'd0;
              push               = 1'b1;
              evt.node_number    = node_num;
              evt.variable_index = held_variable;
              evt.low_reference  = held_low_ref;
              evt.high_reference = sw;
              nodes_done_next    = node_num;
              if (node_num == nodes_expected) begin
                evt.kind   = EV_NODE_LAST;
                phase_next = PH_DONE;
              end else begin
                evt.kind   = EV_NODE;
                phase_next = PH_VAR;
              end
            end else begin
              field_cnt_next = field_cnt + 3'd1;
            end
          end
          default: begin
            // finished: drop bytes until the end marker
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      field_cnt  <= 3'd0;
      magic_bad  <= 1'b0;
      nodes_done <= 32'd0;
    end else begin
      phase      <= phase_next;
      field_cnt  <= field_cnt_next;
      magic_bad  <= magic_bad_next;
      nodes_done <= nodes_done_next;
    end
  end

  // Field registers and the running length verdict; the verdict settles
  // well before the structure can end
  always_ff @(posedge clk) begin
    declared_length <= declared_length_next;
    nodes_expected  <= nodes_expected_next;
    shift_word      <= shift_word_next;
    held_variable   <= held_variable_next;
    held_low_ref    <= held_low_ref_next;
    implied_bytes   <= implied_bytes_next;
    len_short       <= {27'd0, implied_bytes} < cap;
    len_over        <= {27'd0, implied_bytes} > cap;
  end

endmodule

// File: hdl/bsrp_queue.sv
// Short event queue between the parse front and the result back end.
// Depends on bsrp_pkg.
module bsrp_queue
  import bsrp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  parse_event_t  push_data,
  input  logic          pop,
  output parse_event_t  head,
  output queue_status_t status
);

  parse_event_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0]   fill;

  assign head            = entries[rd_ptr];
  assign status.nonempty = (fill != '0);
  assign status.full     = (fill == QUEUE_CW'(QUEUE_DEPTH));

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QUEUE_CW'(1);
      end else if (pop && !push) begin
        fill <= fill - QUEUE_CW'(1);
      end
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/bsrp_back.sv
// Back end: expands queued events into result items behind an output register.
// Depends on bsrp_pkg.
module bsrp_back
  import bsrp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  parse_event_t  head,
  input  queue_status_t status,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output result_item_t  result
);

  logic         second;
  logic         load;
  logic         two_part;
  result_item_t first_res, finish_res;

  assign load     = status.nonempty && (!result_valid || !result_stall);
  assign two_part = (head.kind == EV_NODE_LAST) || (head.kind == EV_TERMINAL);
  assign pop      = load && (second || !two_part);

  // First result of an event
  always_comb begin
    first_res             = '0;
    first_res.record_kind = KIND_ERROR;
    first_res.error_code  = ERR_NONE;
    unique case (head.kind)
      EV_NODE, EV_NODE_LAST: begin
        first_res.record_kind    = KIND_NODE;
        first_res.node_number    = head.node_number;
        first_res.variable_index = head.variable_index;
        first_res.low_reference  = head.low_reference;
        first_res.high_reference = head.high_reference;
        first_res.last_of_run    = (head.kind == EV_NODE);
      end
      EV_TERMINAL: begin
        first_res.record_kind    = KIND_TERMINAL;
        first_res.terminal_value = head.terminal_value;
      end
      default: begin
        first_res.record_kind = KIND_ERROR;
        first_res.error_code  = head.error_code;
        first_res.last_of_run = 1'b1;
      end
    endcase
  end

  // Closing result: length check verdict
  always_comb begin
    finish_res             = '0;
    finish_res.last_of_run = 1'b1;
    priority if (head.len_short) begin
      finish_res.record_kind = KIND_ERROR;
      finish_res.error_code  = ERR_EXTRA_DATA;
    end else if (head.len_over) begin
      finish_res.record_kind = KIND_ERROR;
      finish_res.error_code  = ERR_READ_TOO_MUCH;
    end else begin
      finish_res.record_kind = KIND_COMPLETE;
      finish_res.error_code  = ERR_NONE;
      finish_res.node_number = head.node_number;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      second       <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      if (second) begin
        second <= 1'b0;
      end else if (two_part) begin
        second <= 1'b1;
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= second ? finish_res : first_res;
    end
  end

endmodule

// File: hdl/bdd_stream_record_parser.sv
// Top level of the decision-diagram set stream parser.
// Depends on bsrp_pkg, bsrp_front, bsrp_queue and bsrp_back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------
//   bytes    | byte_valid / byte_stall     | byte_data (byte_item_t)
//   results  | result_valid / result_stall | result (result_item_t)
//
// One byte is taken per cycle while the queue is not full; its event is written
// into the queue and then loaded into the output register, which waits while a
// valid result is stalled. Results leave at one per cycle while result_stall
// is low. An input that yields two results holds its event in the queue until
// both results are loaded. The input stalls only when the four-entry queue
// is full. Reset is synchronous and leaves the parser expecting the magic string.
module bdd_stream_record_parser
  import bsrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic          accept;
  logic          q_push;
  logic          q_pop;
  parse_event_t  q_in;
  parse_event_t  q_head;
  queue_status_t q_status;

  assign byte_stall = q_status.full;
  assign accept     = byte_valid && !q_status.full;

  bsrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_data (byte_data),
    .push      (q_push),
    .evt       (q_in)
  );

  bsrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  bsrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .status       (q_status),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef ASSERT_OFF
  // No event is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_push)
    else $error("event queue overflow");

  // An error always closes the run of its input
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.record_kind == KIND_ERROR) |-> result.last_of_run)
    else $error("error result not marked last");

  // A terminal set result is always followed by its length verdict
  a_terminal_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.record_kind == KIND_TERMINAL) |-> !result.last_of_run)
    else $error("terminal result marked last");
`endif

endmodule
